### design/lzss_pkg.sv
// Shared types and constants for the LZSS stream decoder.
// Used by the front parser, the command queue, the back end and the top level.
package lzss_pkg;

    // History window and counter widths.
    localparam int WINDOW_DEPTH  = 4096;
    localparam int WIN_AW        = $clog2(WINDOW_DEPTH);
    localparam int COUNT_W       = 32;
    localparam int CNT_W         = 5;
    localparam int MIN_MATCH     = 3;
    localparam int FLAG_W        = 8;
    localparam int FLAG_LEFT_W   = 4;

    // Command queue between the front and back parts.
    localparam int Q_DEPTH       = 2;
    localparam int Q_AW          = $clog2(Q_DEPTH);

    // Configuration registers.
    localparam int                  PADDR_W        = 3;
    localparam logic                RAW_SIZE_INDEX = 1'b0;
    localparam logic [COUNT_W-1:0]  RAW_SIZE_RESET = 32'd1;

    // Parse phase of the packed stream.
    typedef enum logic [1:0] {
        PH_FLAG   = 2'd0,
        PH_LIT    = 2'd1,
        PH_MATCH1 = 2'd2,
        PH_MATCH2 = 2'd3
    } phase_t;

    // Kind of work handed from the front to the back.
    typedef enum logic [1:0] {
        CMD_NONE = 2'd0,
        CMD_LIT  = 2'd1,
        CMD_COPY = 2'd2
    } cmd_kind_t;

    // Decoder status as reported on every result.
    typedef enum logic [1:0] {
        ST_RUN      = 2'd0,
        ST_DONE     = 2'd1,
        ST_BAD_DIST = 2'd2,
        ST_TRUNC    = 2'd3
    } status_t;

    // Back end sequencer states.
    typedef enum logic [1:0] {
        B_IDLE = 2'd0,
        B_EXEC = 2'd1,
        B_COPY = 2'd2
    } back_state_t;

    // One classified input byte.
    typedef struct packed {
        cmd_kind_t         kind;
        logic [7:0]        data;
        logic [WIN_AW-1:0] distance;
        logic [CNT_W-1:0]  cnt;
        logic              last;
    } cmd_t;

endpackage

### design/lzss_front.sv
// Front parser: accepts packed bytes, tracks flag bits and classifies each byte.
// Depends on lzss_pkg for the phase and command types.
module lzss_front
    import lzss_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] packed_byte,
    input  logic       stream_end,
    input  logic       q_full,
    output logic       push,
    output cmd_t       push_cmd
);

    phase_t                 phase_reg, phase_next;
    logic [FLAG_W-1:0]      flag_bits_reg, flag_bits_next;
    logic [FLAG_LEFT_W-1:0] flags_left_reg, flags_left_next;
    logic [7:0]             first_reg, first_next;
    logic                   accept;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign push     = accept;

    // Classify the byte and work out the next parse phase.
    always_comb
    begin
        logic [FLAG_W-1:0]      bits;
        logic [FLAG_LEFT_W-1:0] left;
        logic                   pop_flag;

        bits              = flag_bits_reg;
        left              = flags_left_reg;
        pop_flag          = 1'b0;
        phase_next        = phase_reg;
        first_next        = first_reg;
        push_cmd.kind     = CMD_NONE;
        push_cmd.data     = packed_byte;
        push_cmd.distance = {first_reg[7:4], packed_byte};
        push_cmd.cnt      = {1'b0, first_reg[3:0]} + CNT_W'(MIN_MATCH);
        push_cmd.last     = stream_end;

        unique case (phase_reg)
            PH_FLAG:
            begin
                bits     = packed_byte;
                left     = FLAG_LEFT_W'(FLAG_W);
                pop_flag = 1'b1;
            end
            PH_LIT:
            begin
                push_cmd.kind = CMD_LIT;
                pop_flag      = 1'b1;
            end
            PH_MATCH1:
            begin
                first_next = packed_byte;
                phase_next = PH_MATCH2;
            end
            PH_MATCH2:
            begin
                push_cmd.kind = CMD_COPY;
                pop_flag      = 1'b1;
            end
            default:
            begin
                phase_next = PH_FLAG;
            end
        endcase

        // After a token the next flag bit selects the kind of the next byte.
        if (pop_flag)
        begin
            if (left == '0)
            begin
                phase_next = PH_FLAG;
            end
            else
            begin
                phase_next = bits[FLAG_W-1] ? PH_MATCH1 : PH_LIT;
                bits       = {bits[FLAG_W-2:0], 1'b0};
                left       = left - 1'b1;
            end
        end

        flag_bits_next  = bits;
        flags_left_next = left;
    end

    // Parser state advances on every transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_FLAG;
            flag_bits_reg  <= '0;
            flags_left_reg <= '0;
            first_reg      <= '0;
        end
        else if (accept)
        begin
            phase_reg      <= phase_next;
            flag_bits_reg  <= flag_bits_next;
            flags_left_reg <= flags_left_next;
            first_reg      <= first_next;
        end
    end

endmodule

### design/lzss_cmd_queue.sv
// Short command queue that decouples the front parser from the back end.
// Depends on lzss_pkg for the command type and depth.
module lzss_cmd_queue
    import lzss_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output cmd_t head
);

    cmd_t            entry_reg [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg;
    logic [Q_AW-1:0] rd_ptr_reg;
    logic [Q_AW:0]   fill_reg;

    assign full       = (fill_reg == (Q_AW+1)'(Q_DEPTH));
    assign head_valid = (fill_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];

    // Pointer and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

### design/lzss_back.sv
// Back end: executes commands against the history window and drives results.
// Depends on lzss_pkg; holds the 4096-byte history memory.
module lzss_back
    import lzss_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [COUNT_W-1:0] raw_size,
    input  logic               head_valid,
    input  cmd_t               head,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [7:0]         out_byte,
    output logic               has_byte,
    output logic               run_last,
    output status_t            out_status
);

    back_state_t        state_reg, state_next;
    cmd_t               cmd_reg, cmd_next;
    status_t            status_reg, status_next;
    logic [WIN_AW-1:0]  wp_reg, wp_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [WIN_AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   rem_reg, rem_next;
    logic               out_valid_reg, out_valid_next;
    logic [7:0]         out_byte_reg, out_byte_next;
    logic               has_byte_reg, has_byte_next;
    logic               run_last_reg, run_last_next;
    status_t            out_status_reg, out_status_next;

    logic [7:0]         history [WINDOW_DEPTH];
    logic [7:0]         rd_data_reg;
    logic               byp_reg;
    logic [7:0]         byp_data_reg;

    logic               can_load;
    logic               mem_we;
    logic [7:0]         mem_wdata;
    logic               rd_en;
    logic [WIN_AW-1:0]  rd_addr;
    logic [COUNT_W-1:0] count_inc;
    logic               done_inc;
    logic [7:0]         copy_byte;

    assign can_load  = !out_valid_reg || !out_stall;
    assign count_inc = count_reg + 1'b1;
    assign done_inc  = (count_inc >= raw_size);
    assign copy_byte = byp_reg ? byp_data_reg : rd_data_reg;

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign has_byte   = has_byte_reg;
    assign run_last   = run_last_reg;
    assign out_status = out_status_reg;

    // Sequencer: next state, history access and result load.
    always_comb
    begin
        status_t st;
        logic    fin;

        st              = status_reg;
        fin             = 1'b0;
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        status_next     = status_reg;
        wp_next         = wp_reg;
        count_next      = count_reg;
        rd_ptr_next     = rd_ptr_reg;
        rem_next        = rem_reg;
        pop             = 1'b0;
        mem_we          = 1'b0;
        mem_wdata       = cmd_reg.data;
        rd_en           = 1'b0;
        rd_addr         = rd_ptr_reg + 1'b1;
        out_valid_next  = out_stall ? out_valid_reg : 1'b0;
        out_byte_next   = out_byte_reg;
        has_byte_next   = has_byte_reg;
        run_last_next   = run_last_reg;
        out_status_next = out_status_reg;

        unique case (state_reg)
            B_IDLE:
            begin
                // Take a command and apply the completion test at its start.
                if (head_valid)
                begin
                    pop        = 1'b1;
                    cmd_next   = head;
                    state_next = B_EXEC;
                    if (status_reg == ST_RUN && count_reg >= raw_size)
                    begin
                        status_next = ST_DONE;
                    end
                end
            end

            B_EXEC:
            begin
                if (status_reg != ST_RUN)
                begin
                    // Sticky status: the byte is ignored.
                    if (can_load)
                    begin
                        out_valid_next  = 1'b1;
                        out_byte_next   = '0;
                        has_byte_next   = 1'b0;
                        run_last_next   = 1'b1;
                        out_status_next = status_reg;
                        state_next      = B_IDLE;
                    end
                end
                else
                begin
                    unique case (cmd_reg.kind)
                        CMD_LIT:
                        begin
                            if (can_load)
                            begin
                                mem_we     = 1'b1;
                                wp_next    = wp_reg + 1'b1;
                                count_next = count_inc;
                                if (done_inc)
                                begin
                                    st = ST_DONE;
                                end
                                else
                                begin
                                    st = cmd_reg.last ? ST_TRUNC : ST_RUN;
                                end
                                status_next     = st;
                                out_valid_next  = 1'b1;
                                out_byte_next   = cmd_reg.data;
                                has_byte_next   = 1'b1;
                                run_last_next   = 1'b1;
                                out_status_next = st;
                                state_next      = B_IDLE;
                            end
                        end
                        CMD_COPY:
                        begin
                            // A bad distance sets the status; the sticky path reports it.
                            if (cmd_reg.distance == '0 ||
                                {{(COUNT_W-WIN_AW){1'b0}}, cmd_reg.distance} > count_reg)
                            begin
                                status_next = ST_BAD_DIST;
                            end
                            else
                            begin
                                rd_en       = 1'b1;
                                rd_addr     = wp_reg - cmd_reg.distance;
                                rd_ptr_next = rd_addr;
                                rem_next    = cmd_reg.cnt;
                                state_next  = B_COPY;
                            end
                        end
                        default:
                        begin
                            // Flag byte or first match byte: no data out.
                            if (can_load)
                            begin
                                st              = cmd_reg.last ? ST_TRUNC : ST_RUN;
                                status_next     = st;
                                out_valid_next  = 1'b1;
                                out_byte_next   = '0;
                                has_byte_next   = 1'b0;
                                run_last_next   = 1'b1;
                                out_status_next = st;
                                state_next      = B_IDLE;
                            end
                        end
                    endcase
                end
            end

            B_COPY:
            begin
                // One history byte per cycle while the output is not stalled; the next read is issued alongside.
                if (can_load)
                begin
                    mem_we     = 1'b1;
                    mem_wdata  = copy_byte;
                    wp_next    = wp_reg + 1'b1;
                    count_next = count_inc;
                    if (done_inc)
                    begin
                        st  = ST_DONE;
                        fin = 1'b1;
                    end
                    else if (rem_reg == CNT_W'(1))
                    begin
                        st  = cmd_reg.last ? ST_TRUNC : ST_RUN;
                        fin = 1'b1;
                    end
                    else
                    begin
                        st          = ST_RUN;
                        rd_en       = 1'b1;
                        rd_ptr_next = rd_addr;
                        rem_next    = rem_reg - 1'b1;
                    end
                    status_next     = st;
                    out_valid_next  = 1'b1;
                    out_byte_next   = copy_byte;
                    has_byte_next   = 1'b1;
                    run_last_next   = fin;
                    out_status_next = st;
                    state_next      = fin ? B_IDLE : B_COPY;
                end
            end

            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            status_reg    <= ST_RUN;
            wp_reg        <= '0;
            count_reg     <= '0;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            status_reg    <= status_next;
            wp_reg        <= wp_next;
            count_reg     <= count_next;
            rem_reg       <= rem_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        rd_ptr_reg     <= rd_ptr_next;
        out_byte_reg   <= out_byte_next;
        has_byte_reg   <= has_byte_next;
        run_last_reg   <= run_last_next;
        out_status_reg <= out_status_next;
    end

    // History memory with registered read; a read of the byte written in
    // the same cycle takes the write data instead.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            history[wp_reg] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_data_reg  <= history[rd_addr];
            byp_reg      <= mem_we && (rd_addr == wp_reg);
            byp_data_reg <= mem_wdata;
        end
    end

endmodule

### design/lzss_stream_decoder.sv
// LZSS stream decoder top level: configuration port, front parser, queue, back end.
// Depends on lzss_pkg, lzss_front, lzss_cmd_queue and lzss_back.
//
// Usage: set raw_size over the APB port (byte address 0) while the block is
// idle, then send the packed stream after its header, one byte per transfer
// on in_valid/in_stall, with stream_end on the last byte available. Every
// input byte gives one or more results on out_valid/out_stall: out_byte with
// has_byte, status, and run_last on the final result of that byte.
// Throughput: a flag byte, a first match byte or a literal passes through the
// idle and execute states of the back end, a bad distance through the execute
// state again; a match then reads its copied bytes one at a time in the copy
// state, set by the single history read port. The front part takes one byte
// per cycle into a two-entry command queue while the queue is not full, so
// input transfers run ahead of the back end by up to two bytes.
// With an empty queue and an idle back end, a result without a copied byte
// passes the queue entry, the command register and the result register; the
// first byte of a match also passes the registered history read.
// Reset clears the parser, the counters and the status to running, and sets
// raw_size to 1. The history needs no clearing. A stall on the output holds the
// result register and pauses the back end; the queue then fills and in_stall rises.
module lzss_stream_decoder
    import lzss_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         packed_byte,
    input  logic               stream_end,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [7:0]         out_byte,
    output logic               has_byte,
    output logic               run_last,
    output logic [1:0]         status,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [COUNT_W-1:0] raw_size_reg;
    logic               cfg_write;
    logic               q_full;
    logic               push;
    cmd_t               push_cmd;
    logic               pop;
    logic               head_valid;
    cmd_t               head;
    status_t            out_status;

    // Register file: raw_size only.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[PADDR_W-1] == RAW_SIZE_INDEX);
    assign prdata    = (paddr[PADDR_W-1] == RAW_SIZE_INDEX) ? raw_size_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_size_reg <= RAW_SIZE_RESET;
        end
        else if (cfg_write)
        begin
            raw_size_reg <= pwdata;
        end
    end

    // Front parser.
    lzss_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .packed_byte (packed_byte),
        .stream_end  (stream_end),
        .q_full      (q_full),
        .push        (push),
        .push_cmd    (push_cmd)
    );

    // Command queue.
    lzss_cmd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    // Back end.
    lzss_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .raw_size   (raw_size_reg),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .has_byte   (has_byte),
        .run_last   (run_last),
        .out_status (out_status)
    );

    assign status = out_status;

endmodule

### dv/testbench.sv
// Self-checking testbench for lzss_stream_decoder: drives packed LZSS streams.
// Depends on lzss_pkg for the parse phase, status codes and register layout.
// Holds its own model of the decoder state, used to predict the results.
`timescale 1ns / 1ps

module testbench;
    import lzss_pkg::*;

    localparam int CLK_HALF_NS  = 5;
    localparam int RESET_CYCLES = 6;
    localparam int DRAIN_CYCLES = 10;
    localparam int HOLD_CYCLES  = 400;
    localparam int MAX_REPORTS  = 10;
    localparam int TIMEOUT_NS   = 5_000_000;
    localparam int MAX_DIST     = WINDOW_DEPTH - 1;

    localparam logic [PADDR_W-1:0] RAW_SIZE_ADDR = PADDR_W'(4 * int'(RAW_SIZE_INDEX));
    localparam logic [PADDR_W-1:0] UNUSED_ADDR   = PADDR_W'(4);

    // Only one terminal status can be reached per reset, so the run picks one.
    typedef enum logic [1:0] {
        END_COMPLETE,
        END_ZERO_DIST,
        END_FAR_DIST,
        END_TRUNCATE
    } ending_t;

    typedef struct packed {
        logic [7:0] data;
        logic       has;
        logic       last;
        status_t    st;
    } dec_result_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [7:0]         packed_byte;
    logic               stream_end;
    logic               out_valid;
    logic               out_stall;
    logic [7:0]         out_byte;
    logic               has_byte;
    logic               run_last;
    logic [1:0]         status;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    // Decoder state as the testbench expects it.
    logic [7:0]         hist_mem [WINDOW_DEPTH];
    logic [WIN_AW-1:0]  hist_wp   = '0;
    logic [COUNT_W-1:0] made_cnt  = '0;
    logic [7:0]         flag_reg  = '0;
    int                 flag_cnt  = 0;
    phase_t             ph        = PH_FLAG;
    logic [7:0]         match_hi  = '0;
    status_t            st_now    = ST_RUN;
    logic [COUNT_W-1:0] size_cfg  = RAW_SIZE_RESET;

    dec_result_t        step_res [18];
    int                 step_n;
    dec_result_t        pending_results [$];

    // Stream generator knobs.
    int                 snd_idle_pct = 0;
    int                 rcv_idle_pct = 0;
    int                 match_pct    = 50;
    int                 long_pct     = 25;
    int                 noise_pct    = 0;
    logic               corrupt_dist = 1'b0;
    logic [WIN_AW-1:0]  plan_dist    = '0;
    ending_t            ending;

    // Receiver hold-off requests and run statistics.
    int                 hold_asked   = 0;
    int                 hold_served  = 0;
    int                 err_cnt      = 0;
    int                 items_sent   = 0;
    int                 results_seen = 0;
    int                 stall_seen   = 0;
    int                 wrap_cnt     = 0;
    int                 cfg_writes   = 0;

    lzss_stream_decoder u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .packed_byte (packed_byte),
        .stream_end  (stream_end),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .has_byte    (has_byte),
        .run_last    (run_last),
        .status      (status),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF_NS clk = ~clk;
    end

    // Failures are counted; only the first few are printed.
    task automatic log_fault(input string what);
        err_cnt++;
        if (err_cnt <= MAX_REPORTS)
            $display("%0t ns: %s", $time, what);
    endtask

    // Write one decoded byte into the expected history and the result list.
    function automatic void record_byte(input logic [7:0] b);
        hist_mem[hist_wp] = b;
        hist_wp = hist_wp + 1'b1;
        if (hist_wp == '0)
            wrap_cnt++;
        made_cnt = made_cnt + 1'b1;
        if (made_cnt >= size_cfg)
            st_now = ST_DONE;
        step_res[step_n] = '{data: b, has: 1'b1, last: 1'b0, st: st_now};
        step_n++;
    endfunction

    // Pop the next flag bit, or go back to waiting for a flag byte.
    function automatic void advance_flag();
        if (flag_cnt == 0)
            ph = PH_FLAG;
        else
        begin
            ph = flag_reg[7] ? PH_MATCH1 : PH_LIT;
            flag_reg = flag_reg << 1;
            flag_cnt--;
        end
    endfunction

    // Work out the results caused by one accepted packed byte.
    function automatic void predict_decode(input logic [7:0] b, input logic e);
        logic [WIN_AW-1:0] match_dist;
        logic [WIN_AW-1:0] src;
        int                len;
        int                k;
        step_n = 0;
        if (st_now == ST_RUN && made_cnt >= size_cfg)
            st_now = ST_DONE;
        if (st_now == ST_RUN)
        begin
            case (ph)
                PH_FLAG:
                begin
                    flag_reg = b;
                    flag_cnt = FLAG_W;
                    advance_flag();
                end
                PH_LIT:
                begin
                    record_byte(b);
                    advance_flag();
                end
                PH_MATCH1:
                begin
                    match_hi = b;
                    ph = PH_MATCH2;
                end
                default:
                begin
                    match_dist = {match_hi[7:4], b};
                    len = int'(match_hi[3:0]) + MIN_MATCH;
                    if (match_dist == '0 || COUNT_W'(match_dist) > made_cnt)
                        st_now = ST_BAD_DIST;
                    else
                    begin
                        // The copy stops as soon as the block completes.
                        for (k = 0; k < len && st_now == ST_RUN; k++)
                        begin
                            src = hist_wp - match_dist;
                            record_byte(hist_mem[src]);
                        end
                        advance_flag();
                    end
                end
            endcase
            if (st_now == ST_RUN && e)
                st_now = ST_TRUNC;
        end
        if (step_n == 0)
        begin
            step_res[0] = '{data: 8'h00, has: 1'b0, last: 1'b0, st: st_now};
            step_n = 1;
        end
        step_res[step_n-1].last = 1'b1;
        step_res[step_n-1].st = st_now;
        for (k = 0; k < step_n; k++)
            pending_results.push_back(step_res[k]);
    endfunction

    // Next well-formed byte for the current parse phase.
    function automatic logic [7:0] stream_byte();
        logic [7:0] b;
        int         k;
        int         len;
        int         avail;
        int         pick;
        int         d;
        case (ph)
            PH_FLAG:
            begin
                for (k = 0; k < FLAG_W; k++)
                    b[k] = ($urandom_range(0, 99) < match_pct);
                // Nothing can be copied before the first byte exists.
                if (made_cnt == '0)
                    b[7] = 1'b0;
            end
            PH_LIT:
                b = 8'($urandom_range(0, 255));
            PH_MATCH1:
            begin
                pick = $urandom_range(0, 99);
                if (pick < long_pct)
                    len = 18;
                else if (pick < long_pct + 15)
                    len = MIN_MATCH;
                else
                    len = $urandom_range(MIN_MATCH, 18);
                avail = (made_cnt > COUNT_W'(MAX_DIST)) ? MAX_DIST : int'(made_cnt);
                pick = $urandom_range(0, 99);
                if (corrupt_dist && ending == END_FAR_DIST && avail < MAX_DIST)
                    d = $urandom_range(avail + 1, MAX_DIST);
                else if (corrupt_dist)
                    d = 0;
                else if (pick < 20)
                    d = 1;
                else if (pick < 35)
                    d = avail;
                else if (pick < 55)
                    d = $urandom_range(1, (avail < 24) ? avail : 24);
                else
                    d = $urandom_range(1, avail);
                plan_dist = WIN_AW'(d);
                b = {plan_dist[11:8], 4'(len - MIN_MATCH)};
            end
            default:
                b = plan_dist[7:0];
        endcase
        return b;
    endfunction

    // Offer one packed byte and hold it until the block takes it.
    task automatic send_item(input logic [7:0] b, input logic e);
        while ($urandom_range(0, 99) < snd_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        packed_byte <= b;
        stream_end  <= e;
        @(posedge clk);
        while (in_stall)
        begin
            stall_seen++;
            @(posedge clk);
        end
        predict_decode(b, e);
        items_sent++;
        @(negedge clk);
    endtask

    // Send a run of well-formed stream bytes, mixed with harmless noise bytes.
    task automatic send_stream(input int count);
        logic [7:0]        b;
        logic              e;
        logic [WIN_AW-1:0] d;
        int                n;
        for (n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 99) < noise_pct && (ph == PH_FLAG || ph == PH_LIT ||
                    (ph == PH_MATCH1 && made_cnt >= COUNT_W'(MAX_DIST))))
            begin
                b = 8'($urandom_range(0, 255));
                plan_dist = {b[7:4], 8'($urandom_range((b[7:4] == 4'h0) ? 1 : 0, 255))};
            end
            else
                b = stream_byte();
            // The byte that completes the block is marked as the end of the stream.
            e = 1'b0;
            if (st_now == ST_RUN)
            begin
                d = {match_hi[7:4], b};
                if (made_cnt >= size_cfg)
                    e = 1'b1;
                else if (ph == PH_LIT)
                    e = (made_cnt + 1 >= size_cfg);
                else if (ph == PH_MATCH2 && d != '0 && COUNT_W'(d) <= made_cnt)
                    e = (made_cnt + COUNT_W'(match_hi[3:0]) + MIN_MATCH >= size_cfg);
            end
            send_item(b, e);
        end
    endtask

    // Let every expected result arrive, then wait out the drain time.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    // One APB transfer; leaves the bus idle afterwards.
    task automatic apb_transfer(input logic wr, input logic [PADDR_W-1:0] addr,
                                input logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    // Write raw_size and read it back.
    task automatic set_raw_size(input logic [31:0] value);
        logic [31:0] rd;
        apb_transfer(1'b1, RAW_SIZE_ADDR, value, rd);
        size_cfg = value;
        cfg_writes++;
        apb_transfer(1'b0, RAW_SIZE_ADDR, 32'h0, rd);
        if (rd !== value)
            log_fault($sformatf("raw_size read back %08h, expected %08h", rd, value));
    endtask

    // Reset value of raw_size, then the largest size, then a write to an unused address.
    task automatic test_config_after_reset();
        logic [31:0] rd;
        apb_transfer(1'b0, RAW_SIZE_ADDR, 32'h0, rd);
        if (rd !== RAW_SIZE_RESET)
            log_fault($sformatf("raw_size after reset %08h, expected %08h", rd, RAW_SIZE_RESET));
        set_raw_size(32'hFFFF_FFFF);
        apb_transfer(1'b1, UNUSED_ADDR, $urandom, rd);
        apb_transfer(1'b0, RAW_SIZE_ADDR, 32'h0, rd);
        if (rd !== size_cfg)
            log_fault($sformatf("raw_size changed to %08h by an unused address", rd));
    endtask

    // Fixed tokens: literal extremes, short, long and overlapping matches.
    task automatic test_directed_tokens();
        logic [7:0] seq [$];
        int         k;
        // All-literal flag byte, then a mixed one, then an all-match one.
        seq = '{8'h00, 8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h80, 8'h7F, 8'hFE,
                8'hA5, 8'h00, 8'h01, 8'hFF, 8'h0F, 8'h0C, 8'h00, 8'h33,
                8'h07, 8'h20, 8'hC3, 8'h0F, 8'h07, 8'hFF};
        for (k = 0; k < seq.size(); k++)
            send_item(seq[k], 1'b0);
    endtask

    // Random stream while the receiver stalls more than the sender idles.
    task automatic test_random_stream();
        noise_pct = 10;
        send_stream(35);
        wait_for_results();
    endtask

    // Swapped idling, a new raw_size, and a run made mostly of long matches.
    task automatic test_long_matches();
        snd_idle_pct = 60;
        rcv_idle_pct = 26;
        set_raw_size($urandom_range(32'h0010_0000, 32'hFFFF_FFFE));
        send_stream(15);
        match_pct = 100;
        long_pct  = 90;
        noise_pct = 0;
        send_stream(20);
        match_pct = 50;
        long_pct  = 25;
        noise_pct = 10;
        send_stream(15);
        wait_for_results();
    endtask

    // No idling, then a long receiver hold-off while bytes keep coming.
    task automatic test_back_pressure();
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        set_raw_size(32'hFFFF_FFFF);
        send_stream(10);
        hold_asked++;
        send_stream(30);
        wait_for_results();
    endtask

    // Drive the block into its terminal status, then check that it stays there.
    task automatic test_final_status();
        int k;
        int burst;
        noise_pct = 0;
        case (ending)
            END_COMPLETE:
            begin
                k = $urandom_range(0, 2);
                if (k == 0)
                    set_raw_size(made_cnt + $urandom_range(1, 40));
                else if (k == 1)
                    set_raw_size(32'd1);
                else
                    set_raw_size(made_cnt);
            end
            END_ZERO_DIST, END_FAR_DIST:
            begin
                corrupt_dist = 1'b1;
                match_pct    = 100;
            end
            default:
                send_stream($urandom_range(0, 6));
        endcase
        if (ending == END_TRUNCATE)
            send_item(stream_byte(), 1'b1);
        while (st_now == ST_RUN)
            send_stream(1);
        // Once the status is set, every byte is ignored.
        burst = $urandom_range(3, 6);
        for (k = 0; k < burst; k++)
            send_item(8'($urandom_range(0, 255)), (k == burst - 1) ? 1'b1 : 1'($urandom));
        wait_for_results();
    endtask

    // Receiver stall: random, or held high for a long stretch on request.
    initial
    begin : rx_stall_gen
        int hold_left;
        hold_left = 0;
        forever
        begin
            if (hold_asked != hold_served)
            begin
                hold_served = hold_asked;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
            @(negedge clk);
        end
    end

    // Compare each result transfer with the oldest expected one.
    always @(posedge clk)
    begin : result_check
        dec_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (pending_results.size() == 0)
                log_fault($sformatf("unexpected result: byte %02h has %0b last %0b status %0d",
                                    out_byte, has_byte, run_last, status));
            else
            begin
                want = pending_results.pop_front();
                if (out_byte !== want.data || has_byte !== want.has ||
                        run_last !== want.last || status !== want.st)
                    log_fault($sformatf({"result %0d: expected byte %02h has %0b last %0b ",
                                         "status %0d, got byte %02h has %0b last %0b status %0d"},
                                        results_seen, want.data, want.has, want.last,
                                        want.st, out_byte, has_byte, run_last, status));
            end
        end
    end

    initial
    begin
        #TIMEOUT_NS;
        $display("Timeout with %0d results still expected.", pending_results.size());
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        packed_byte = 8'h00;
        stream_end  = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = 32'h0;
        ending      = ending_t'($urandom_range(0, 3));
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        snd_idle_pct = 26;
        rcv_idle_pct = 60;
        test_config_after_reset();
        test_directed_tokens();
        test_random_stream();
        test_long_matches();
        test_back_pressure();
        test_final_status();

        if (pending_results.size() != 0)
            log_fault($sformatf("%0d expected results never arrived", pending_results.size()));
        $display("Sent %0d packed bytes, checked %0d results, decoded %0d bytes (%0d window wraps).",
                 items_sent, results_seen, made_cnt, wrap_cnt);
        $display("Saw %0d input stall cycles over %0d raw_size writes; final status %s, %0d errors.",
                 stall_seen, cfg_writes, st_now.name(), err_cnt);
        if (err_cnt == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
